### hw/rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared widths, types and codes for the swept box collision time block.
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int FIELD_W            = 24;   // Q16.8 box and velocity fields
    localparam int DIST_W             = 27;   // signed entry/exit distances
    localparam int DEN_W              = 24;   // |velocity|
    localparam int PROD_W             = 52;   // distance times |velocity|
    localparam int TIME_FRAC_BITS_DEF = 16;

    typedef logic signed [1:0] t_norm;

    localparam t_norm NORM_ZERO = 2'sb00;
    localparam t_norm NORM_POS  = 2'sb01;
    localparam t_norm NORM_NEG  = 2'sb11;

    // One axis after the first stage: entry/exit times as num/den, den > 0
    // unless the axis velocity is zero.
    typedef struct packed {
        logic signed [DIST_W-1:0] num_e;
        logic signed [DIST_W-1:0] num_x;
        logic [DEN_W-1:0]         den;
        logic                     zero;
        logic                     ie_neg;
    } t_axis;

endpackage

### hw/rtl/sbc_in_if.sv
// ----------------------------------------------------------------------------
// sbc_in_if
// Box pair channel: moving box, its displacement and the still box.
// ----------------------------------------------------------------------------
interface sbc_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [sbc_pkg::FIELD_W-1:0]         mover_x;
    logic signed [sbc_pkg::FIELD_W-1:0]         mover_y;
    logic        [sbc_pkg::FIELD_W-1:0]         mover_w;
    logic        [sbc_pkg::FIELD_W-1:0]         mover_h;
    logic signed [sbc_pkg::FIELD_W-1:0]         vel_x;
    logic signed [sbc_pkg::FIELD_W-1:0]         vel_y;
    logic signed [sbc_pkg::FIELD_W-1:0]         obstacle_x;
    logic signed [sbc_pkg::FIELD_W-1:0]         obstacle_y;
    logic        [sbc_pkg::FIELD_W-1:0]         obstacle_w;
    logic        [sbc_pkg::FIELD_W-1:0]         obstacle_h;

    modport source (output valid, mover_x, mover_y, mover_w, mover_h, vel_x, vel_y,
                    obstacle_x, obstacle_y, obstacle_w, obstacle_h, input ready);
    modport sink   (input valid, mover_x, mover_y, mover_w, mover_h, vel_x, vel_y,
                    obstacle_x, obstacle_y, obstacle_w, obstacle_h, output ready);
endinterface

### hw/rtl/sbc_out_if.sv
// ----------------------------------------------------------------------------
// sbc_out_if
// Collision result channel: hit flag, contact time and contact normal.
// ----------------------------------------------------------------------------
interface sbc_out_if #(
    parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic [TIME_FRAC_BITS:0]   contact_time;
    sbc_pkg::t_norm            normal_x;
    sbc_pkg::t_norm            normal_y;

    modport source (output valid, hit, contact_time, normal_x, normal_y, input ready);
    modport sink   (input valid, hit, contact_time, normal_x, normal_y, output ready);
endinterface

### hw/rtl/swept_box_collision_time.sv
// ----------------------------------------------------------------------------
// swept_box_collision_time
// Swept box against still box: first contact fraction and contact normal.
// ----------------------------------------------------------------------------
// Usage:
//   i_box carries one box pair per word (valid/ready); o_res carries one
//   result word per pair, in order. Accepts one word every cycle while o_res is not stalled.
//   Pipeline stages: one for the per-axis distances, one for the eight
//   cross products, one for the exact compares and the hit decision, then
//   one restoring divider stage per contact time bit, the last of which
//   is the output register.
//   A miss gives hit 0, contact_time one and a zero normal.
//   Reset clears all stage valid bits; no payload is cleared.
//   When o_res stalls with a word waiting, the whole pipeline holds and
//   i_box.ready drops; it rises again as soon as the word is taken.
// ----------------------------------------------------------------------------
module swept_box_collision_time #(
    parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbc_in_if.sink     i_box,
    sbc_out_if.source  o_res
);

    localparam int F  = TIME_FRAC_BITS;
    localparam int DW = sbc_pkg::DIST_W;
    localparam int VW = sbc_pkg::DEN_W;
    localparam int PW = sbc_pkg::PROD_W;

    logic w_en;

    // ------------------------------------------------------------------ stage 1
    function automatic sbc_pkg::t_axis axis_calc(
        input logic signed [sbc_pkg::FIELD_W-1:0] mp,
        input logic        [sbc_pkg::FIELD_W-1:0] ms,
        input logic signed [sbc_pkg::FIELD_W-1:0] v,
        input logic signed [sbc_pkg::FIELD_W-1:0] op,
        input logic        [sbc_pkg::FIELD_W-1:0] os
    );
        sbc_pkg::t_axis   a;
        logic signed [DW-1:0] near_d;
        logic signed [DW-1:0] far_d;
        logic signed [DW-1:0] ie;
        logic signed [DW-1:0] ix;
        logic                 vpos;
        logic                 vneg;
        near_d = DW'(op) - (DW'(mp) + $signed({3'b000, ms}));
        far_d  = (DW'(op) + $signed({3'b000, os})) - DW'(mp);
        vneg   = v[sbc_pkg::FIELD_W-1];
        vpos   = !vneg && (v != '0);
        ie     = vpos ? near_d : far_d;
        ix     = vpos ? far_d : near_d;
        a.ie_neg = ie[DW-1];
        a.zero   = (v == '0);
        a.num_e  = vneg ? -ie : ie;
        a.num_x  = vneg ? -ix : ix;
        a.den    = vneg ? VW'(-v) : VW'(v);
        return a;
    endfunction

    logic           r1_vld;
    sbc_pkg::t_axis r1_x;
    sbc_pkg::t_axis r1_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_box.valid;
        end
        if (w_en) begin
            r1_x <= axis_calc(i_box.mover_x, i_box.mover_w, i_box.vel_x,
                              i_box.obstacle_x, i_box.obstacle_w);
            r1_y <= axis_calc(i_box.mover_y, i_box.mover_h, i_box.vel_y,
                              i_box.obstacle_y, i_box.obstacle_h);
        end
    end

    // ------------------------------------------------------------------ stage 2
    logic                 r2_vld;
    sbc_pkg::t_axis       r2_x;
    sbc_pkg::t_axis       r2_y;
    logic signed [PW-1:0] r2_p_xe_ye, r2_p_ye_xe, r2_p_xx_yx, r2_p_yx_xx;
    logic signed [PW-1:0] r2_p_xe_yx, r2_p_yx_xe, r2_p_ye_xx, r2_p_xx_ye;
    logic signed [VW:0]   w_dx;
    logic signed [VW:0]   w_dy;

    assign w_dx = $signed({1'b0, r1_x.den});
    assign w_dy = $signed({1'b0, r1_y.den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
        if (w_en) begin
            r2_x       <= r1_x;
            r2_y       <= r1_y;
            r2_p_xe_ye <= PW'(r1_x.num_e * w_dy);
            r2_p_ye_xe <= PW'(r1_y.num_e * w_dx);
            r2_p_xx_yx <= PW'(r1_x.num_x * w_dy);
            r2_p_yx_xx <= PW'(r1_y.num_x * w_dx);
            r2_p_xe_yx <= PW'(r1_x.num_e * w_dy);
            r2_p_yx_xe <= PW'(r1_y.num_x * w_dx);
            r2_p_ye_xx <= PW'(r1_y.num_e * w_dx);
            r2_p_xx_ye <= PW'(r1_x.num_x * w_dy);
        end
    end

    // ------------------------------------------------------------------ stage 3
    logic          w_both_zero, w_ent_gt, w_ent_eq, w_ent_x, w_exit_x, w_late;
    logic          w_bz_x, w_bz_y, w_ao_x, w_ao_y, w_hit;
    sbc_pkg::t_norm w_nx, w_ny;

    always_comb begin
        w_both_zero = r2_x.zero && r2_y.zero;
        if (w_both_zero) begin
            w_ent_gt = 1'b0;
            w_ent_eq = 1'b1;
            w_exit_x = 1'b1;
        end else if (r2_x.zero) begin
            w_ent_gt = 1'b0;
            w_ent_eq = 1'b0;
            w_exit_x = 1'b0;
        end else if (r2_y.zero) begin
            w_ent_gt = 1'b1;
            w_ent_eq = 1'b0;
            w_exit_x = 1'b1;
        end else begin
            w_ent_gt = r2_p_xe_ye > r2_p_ye_xe;
            w_ent_eq = r2_p_xe_ye == r2_p_ye_xe;
            w_exit_x = r2_p_xx_yx <= r2_p_yx_xx;
        end
        w_ent_x = w_ent_gt || w_ent_eq;

        // entry later than exit; both finite unless both axes stand still
        case ({w_ent_x, w_exit_x})
            2'b11:   w_late = r2_x.num_e > r2_x.num_x;
            2'b10:   w_late = r2_p_xe_yx > r2_p_yx_xe;
            2'b01:   w_late = r2_p_ye_xx > r2_p_xx_ye;
            default: w_late = r2_y.num_e > r2_y.num_x;
        endcase
        if (w_both_zero) begin
            w_late = 1'b0;
        end

        w_bz_x = r2_x.zero || r2_x.num_e[DW-1];
        w_bz_y = r2_y.zero || r2_y.num_e[DW-1];
        w_ao_x = !r2_x.zero && (r2_x.num_e > $signed({3'b000, r2_x.den}));
        w_ao_y = !r2_y.zero && (r2_y.num_e > $signed({3'b000, r2_y.den}));
        w_hit  = !(w_late || (w_bz_x && w_bz_y) || w_ao_x || w_ao_y);

        w_nx = sbc_pkg::NORM_ZERO;
        w_ny = sbc_pkg::NORM_ZERO;
        if (w_hit && w_ent_gt) begin
            w_nx = r2_x.ie_neg ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
        end else if (w_hit) begin
            w_ny = r2_y.ie_neg ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
        end
    end

    logic           r3_vld;
    logic           r3_hit;
    sbc_pkg::t_norm r3_nx, r3_ny;
    logic [VW-1:0]  r3_num;
    logic [VW-1:0]  r3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
        if (w_en) begin
            r3_hit <= w_hit;
            r3_nx  <= w_nx;
            r3_ny  <= w_ny;
            // on a hit 0 <= entry num <= den, so the low bits hold it
            r3_num <= w_ent_x ? r2_x.num_e[VW-1:0] : r2_y.num_e[VW-1:0];
            r3_den <= w_ent_x ? r2_x.den : r2_y.den;
        end
    end

    // ------------------------------------------------------------ divider stages
    logic           r_dv_vld [F+1];
    logic           r_dv_hit [F+1];
    sbc_pkg::t_norm r_dv_nx  [F+1];
    sbc_pkg::t_norm r_dv_ny  [F+1];
    logic [VW-1:0]  r_dv_rem [F+1];
    logic [VW-1:0]  r_dv_den [F+1];
    logic [F:0]     r_dv_q   [F+1];

    for (genvar k = 0; k <= F; k++) begin : g_div
        logic           w_pvld, w_phit;
        sbc_pkg::t_norm w_pnx, w_pny;
        logic [VW-1:0]  w_pden;
        logic [F:0]     w_pq;
        logic [VW:0]    w_t;
        logic           w_qb;
        logic [VW-1:0]  n_rem;
        logic [F:0]     n_q;

        if (k == 0) begin : g_first
            assign w_pvld = r3_vld;
            assign w_phit = r3_hit;
            assign w_pnx  = r3_nx;
            assign w_pny  = r3_ny;
            assign w_pden = r3_den;
            assign w_pq   = '0;
            assign w_t    = {1'b0, r3_num};
        end else begin : g_next
            assign w_pvld = r_dv_vld[k-1];
            assign w_phit = r_dv_hit[k-1];
            assign w_pnx  = r_dv_nx[k-1];
            assign w_pny  = r_dv_ny[k-1];
            assign w_pden = r_dv_den[k-1];
            assign w_pq   = r_dv_q[k-1];
            assign w_t    = {r_dv_rem[k-1], 1'b0};
        end

        always_comb begin
            w_qb  = w_t >= {1'b0, w_pden};
            n_rem = w_qb ? VW'(w_t - {1'b0, w_pden}) : w_t[VW-1:0];
            n_q   = w_pq;
            n_q[F-k] = w_qb;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[k] <= w_pvld;
            end
            if (w_en) begin
                r_dv_hit[k] <= w_phit;
                r_dv_nx[k]  <= w_pnx;
                r_dv_ny[k]  <= w_pny;
                r_dv_den[k] <= w_pden;
                r_dv_rem[k] <= n_rem;
                r_dv_q[k]   <= n_q;
            end
        end
    end

    // ------------------------------------------------------------------ outputs
    localparam logic [F:0] TIME_ONE = {1'b1, {F{1'b0}}};

    // hold everything while a finished word waits
    assign w_en         = !r_dv_vld[F] || o_res.ready;
    assign i_box.ready  = w_en;

    assign o_res.valid        = r_dv_vld[F];
    assign o_res.hit          = r_dv_hit[F];
    assign o_res.contact_time = r_dv_hit[F] ? r_dv_q[F] : TIME_ONE;
    assign o_res.normal_x     = r_dv_nx[F];
    assign o_res.normal_y     = r_dv_ny[F];

    // ---------------------------------------------------------------- assertions
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.contact_time <= TIME_ONE))
        else $error("contact time above one");

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.hit) |->
            (o_res.contact_time == TIME_ONE && o_res.normal_x == sbc_pkg::NORM_ZERO &&
             o_res.normal_y == sbc_pkg::NORM_ZERO))
        else $error("miss word carries time or normal");

    a_one_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.hit) |->
            ((o_res.normal_x != sbc_pkg::NORM_ZERO) != (o_res.normal_y != sbc_pkg::NORM_ZERO)))
        else $error("hit word needs exactly one normal axis");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_vld && !w_en) |=> (r3_vld && $stable(r3_num) && $stable(r3_den)))
        else $error("compare stage moved during stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

endmodule

### bench/swept_box_collision_time_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_box_collision_time_checker
// Watches the box pair and result channels, predicts each result with exact
// fraction compares and checks every result word in order.
// ----------------------------------------------------------------------------
module swept_box_collision_time_checker #(
    parameter int TIME_FRAC_BITS = sbc_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sbc_in_if       i_box,
    sbc_out_if      i_res,
    output int      o_err_count,
    output int      o_pending,
    output int      o_hits,
    output int      o_results
);

    typedef struct {
        logic                    hit;
        logic [TIME_FRAC_BITS:0] contact_time;
        sbc_pkg::t_norm          normal_x;
        sbc_pkg::t_norm          normal_y;
    } t_contact;

    // kind: -1 minus infinity, 0 finite num/den with den > 0, +1 plus infinity
    typedef struct {
        int     kind;
        longint num;
        longint den;
    } t_frac;

    t_contact contact_q[$];

    function automatic int frac_cmp(t_frac a, t_frac b);
        longint l, r;
        if (a.kind != b.kind) return (a.kind < b.kind) ? -1 : 1;
        if (a.kind != 0) return 0;
        l = a.num * b.den;
        r = b.num * a.den;
        return (l < r) ? -1 : ((l > r) ? 1 : 0);
    endfunction

    function automatic void sweep_axis(input longint pos, input longint size,
                                       input longint vel, input longint opos,
                                       input longint osize, output longint near_dist,
                                       output t_frac t_in, output t_frac t_out);
        longint far_dist;
        if (vel > 0) begin
            near_dist = opos - (pos + size);
            far_dist  = (opos + osize) - pos;
        end else begin
            near_dist = (opos + osize) - pos;
            far_dist  = opos - (pos + size);
        end
        if (vel == 0) begin
            t_in  = '{-1, 0, 1};
            t_out = '{1, 0, 1};
        end else if (vel > 0) begin
            t_in  = '{0, near_dist, vel};
            t_out = '{0, far_dist, vel};
        end else begin
            t_in  = '{0, -near_dist, -vel};
            t_out = '{0, -far_dist, -vel};
        end
    endfunction

    function automatic t_contact predict_contact();
        longint   near_x, near_y;
        t_frac    in_x, out_x, in_y, out_y, t_enter, t_leave;
        t_contact c;
        sweep_axis(longint'(i_box.mover_x), longint'(i_box.mover_w), longint'(i_box.vel_x),
                   longint'(i_box.obstacle_x), longint'(i_box.obstacle_w), near_x, in_x, out_x);
        sweep_axis(longint'(i_box.mover_y), longint'(i_box.mover_h), longint'(i_box.vel_y),
                   longint'(i_box.obstacle_y), longint'(i_box.obstacle_h), near_y, in_y, out_y);
        t_enter = (frac_cmp(in_x, in_y) >= 0) ? in_x : in_y;
        t_leave = (frac_cmp(out_x, out_y) <= 0) ? out_x : out_y;
        c.hit          = 1'b0;
        c.contact_time = (TIME_FRAC_BITS+1)'(1 << TIME_FRAC_BITS);
        c.normal_x     = sbc_pkg::NORM_ZERO;
        c.normal_y     = sbc_pkg::NORM_ZERO;
        if (frac_cmp(t_enter, t_leave) > 0) return c;
        if ((in_x.kind < 0 || (in_x.kind == 0 && in_x.num < 0)) &&
            (in_y.kind < 0 || (in_y.kind == 0 && in_y.num < 0))) return c;
        if (in_x.kind == 0 && in_x.num > in_x.den) return c;
        if (in_y.kind == 0 && in_y.num > in_y.den) return c;
        c.hit          = 1'b1;
        c.contact_time = (TIME_FRAC_BITS+1)'((t_enter.num << TIME_FRAC_BITS) / t_enter.den);
        if (frac_cmp(in_x, in_y) > 0)
            c.normal_x = (near_x < 0) ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
        else
            c.normal_y = (near_y < 0) ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG;
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_contact exp_c;
        if (i_rst_n) begin
            if (i_box.valid && i_box.ready)
                contact_q.push_back(predict_contact());
            if (i_res.valid && i_res.ready) begin
                o_results++;
                if (contact_q.size() == 0) begin
                    o_err_count++;
                    $display("%0t: unexpected result word hit=%0b time=%0d nx=%0d ny=%0d",
                             $time, i_res.hit, i_res.contact_time,
                             i_res.normal_x, i_res.normal_y);
                end else begin
                    exp_c = contact_q.pop_front();
                    if (exp_c.hit) o_hits++;
                    if (i_res.hit !== exp_c.hit || i_res.contact_time !== exp_c.contact_time ||
                        i_res.normal_x !== exp_c.normal_x ||
                        i_res.normal_y !== exp_c.normal_y) begin
                        o_err_count++;
                        $display("%0t: mismatch expected hit=%0b time=%0d nx=%0d ny=%0d",
                                 $time, exp_c.hit, exp_c.contact_time,
                                 exp_c.normal_x, exp_c.normal_y);
                        $display("%0t:          actual   hit=%0b time=%0d nx=%0d ny=%0d",
                                 $time, i_res.hit, i_res.contact_time,
                                 i_res.normal_x, i_res.normal_y);
                    end
                end
            end
        end
        o_pending = contact_q.size();
    end
endmodule

### bench/swept_box_collision_time_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_box_collision_time_tb
// Streams box pairs into the block with bursty input and a stalling output,
// including one long output hold-off; the checker compares every result.
// ----------------------------------------------------------------------------
module swept_box_collision_time_tb;

    localparam int TFB      = sbc_pkg::TIME_FRAC_BITS_DEF;
    localparam int N_RANDOM = 1300;

    logic i_clk;
    logic i_rst_n;
    int   err_count, pending, hits, results;
    int   n_sent;

    sbc_in_if                        box_if ();
    sbc_out_if #(.TIME_FRAC_BITS(TFB)) res_if ();

    swept_box_collision_time #(.TIME_FRAC_BITS(TFB)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_if.sink),
        .o_res   (res_if.source)
    );

    swept_box_collision_time_checker #(.TIME_FRAC_BITS(TFB)) u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box       (box_if),
        .i_res       (res_if),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_hits      (hits),
        .o_results   (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("swept_box_collision_time_tb: errors");
        $finish;
    end

    // Output side: random stalls, one long hold-off while the sender keeps going.
    initial begin
        res_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        repeat (400) begin
            res_if.ready <= ($urandom_range(0, 3) != 0);
            @(posedge i_clk);
        end
        res_if.ready <= 1'b0;
        repeat (300) @(posedge i_clk);
        forever begin
            case ($urandom_range(0, 2))
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= ($urandom_range(0, 1) != 0);
                default: res_if.ready <= ($urandom_range(0, 4) == 0);
            endcase
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    int burst_left = 0;

    // Hold the word until accepted, then maybe drop valid for a gap.
    task automatic send_pair(int mx, int my, int mw, int mh, int vx, int vy,
                             int ox, int oy, int ow, int oh);
        box_if.valid      <= 1'b1;
        box_if.mover_x    <= mx[23:0];
        box_if.mover_y    <= my[23:0];
        box_if.mover_w    <= mw[23:0];
        box_if.mover_h    <= mh[23:0];
        box_if.vel_x      <= vx[23:0];
        box_if.vel_y      <= vy[23:0];
        box_if.obstacle_x <= ox[23:0];
        box_if.obstacle_y <= oy[23:0];
        box_if.obstacle_w <= ow[23:0];
        box_if.obstacle_h <= oh[23:0];
        do @(posedge i_clk); while (!box_if.ready);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(0, 15);
            if ($urandom_range(0, 1)) begin
                box_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    function automatic int r24();
        return int'($urandom_range(0, 24'hFFFFFF));
    endfunction

    function automatic int rs(int lim);
        return $signed($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic send_shaped();
        int mx, my, mw, mh, vx, vy, ox, oy, f;
        mx = rs(4000); my = rs(4000);
        mw = $urandom_range(0, 800); mh = $urandom_range(0, 800);
        vx = ($urandom_range(0, 7) == 0) ? 0 : rs(3000);
        vy = ($urandom_range(0, 7) == 0) ? 0 : rs(3000);
        // place the obstacle about where the sweep ends up at some fraction
        f  = $urandom_range(0, 256);
        ox = mx + (vx * f) / 256 + rs(300);
        oy = my + (vy * f) / 256 + rs(300);
        if ($urandom_range(0, 5) == 0) vy = vx;
        send_pair(mx, my, mw, mh, vx, vy, ox, oy,
                  $urandom_range(0, 800), $urandom_range(0, 800));
    endtask

    initial begin
        int k;
        n_sent = 0;
        i_rst_n <= 1'b0;
        box_if.valid <= 1'b0;
        box_if.mover_x <= '0; box_if.mover_y <= '0;
        box_if.mover_w <= '0; box_if.mover_h <= '0;
        box_if.vel_x <= '0; box_if.vel_y <= '0;
        box_if.obstacle_x <= '0; box_if.obstacle_y <= '0;
        box_if.obstacle_w <= '0; box_if.obstacle_h <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both velocities zero, overlapping and apart
        send_pair(0, 0, 256, 256, 0, 0, 100, 100, 256, 256);
        send_pair(0, 0, 256, 256, 0, 0, 5000, 5000, 256, 256);
        // contact exactly at the end of the step, and at its start
        send_pair(0, 0, 256, 256, 256, 0, 512, 0, 256, 256);
        send_pair(0, 0, 256, 256, 256, 0, 256, 0, 256, 256);
        // negative velocities on each axis
        send_pair(1000, 0, 100, 100, -512, 0, 600, 0, 100, 100);
        send_pair(0, 1000, 100, 100, 0, -512, 0, 600, 100, 100);
        // equal entry on both axes: normal goes to y
        send_pair(0, 0, 100, 100, 200, 200, 200, 200, 100, 100);
        send_pair(0, 0, 100, 100, -200, -200, -300, -300, 100, 100);
        // already overlapping: both entries below zero
        send_pair(0, 0, 500, 500, 100, 100, 100, 100, 100, 100);
        // entry after exit
        send_pair(0, 0, 10, 10, 300, 30, 150, 290, 10, 10);
        // entry above one
        send_pair(0, 0, 10, 10, 100, 100, 500, 0, 10, 10);
        // x entered last
        send_pair(0, 0, 100, 100, 400, 100, 300, 0, 100, 100);
        // field extremes
        send_pair(-8388608, -8388608, 0, 0, 8388607, 8388607,
                  8388607, 8388607, 16777215, 16777215);
        send_pair(8388607, 8388607, 16777215, 16777215, -8388608, -8388608,
                  -8388608, -8388608, 16777215, 16777215);
        send_pair(-8388608, 0, 16777215, 0, 8388607, 1, 8388607, 0, 0, 0);
        send_pair(8388607, -8388608, 0, 16777215, -1, -8388608, -8388608, 8388607, 0, 0);
        send_pair(0, 0, 0, 0, 1, -1, 1, -1, 0, 0);
        send_pair(0, 0, 0, 0, -8388608, 8388607, -8388608, 8388607, 0, 0);

        for (k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                    send_pair(r24(), r24(), r24(), r24(), r24(), r24(),
                              r24(), r24(), r24(), r24());
                3, 4, 5, 6:
                    send_pair(rs(60000), rs(60000), $urandom_range(0, 30000),
                              $urandom_range(0, 30000), rs(60000), rs(60000),
                              rs(60000), rs(60000), $urandom_range(0, 30000),
                              $urandom_range(0, 30000));
                default:
                    send_shaped();
            endcase
        end
        box_if.valid <= 1'b0;

        // wait for every word to come back
        while (results != n_sent || pending != 0) @(posedge i_clk);
        repeat (TFB + 20) @(posedge i_clk);
        $display("Run covered %0d box pairs, %0d results, %0d of them hits.",
                 n_sent, results, hits);
        if (err_count == 0) begin
            $display("swept_box_collision_time_tb: clean");
        end else begin
            $display("swept_box_collision_time_tb: errors");
        end
        $finish;
    end
endmodule

### sim.f
hw/rtl/sbc_pkg.sv
hw/rtl/sbc_in_if.sv
hw/rtl/sbc_out_if.sv
hw/rtl/swept_box_collision_time.sv
bench/swept_box_collision_time_checker.sv
bench/swept_box_collision_time_tb.sv
